// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset
`define CHK_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("check failed");

// Expression must never be true at a rising edge outside reset
`define CHK_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");

`endif

// File: rtl/i2crm_pkg.sv
// ---------------------------------------------------------------------------
// i2crm_pkg
// Types and constants of the I2C register master.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2crm_pkg;

    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] ACK_LIMIT_RESET = 8'd250;

    // command codes on the mode field
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // bit counter marks
    localparam logic [3:0] BITS_LAST    = 4'd7;
    localparam logic [3:0] BITS_FULL    = 4'd8;
    localparam logic [3:0] BITS_RESTART = 4'd3;

    // which byte of the transaction is on the wire
    typedef enum logic [1:0] {
        STG_DEVICE,
        STG_REGISTER,
        STG_DATA,
        STG_READ_DEVICE
    } stage_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_HIGH,
        PH_START_FALL,
        PH_RESTART_LOW,
        PH_BIT_LOW,
        PH_BIT_HIGH,
        PH_BIT_END,
        PH_ACK_LOW,
        PH_ACK_HIGH,
        PH_READ_LOW,
        PH_READ_HIGH,
        PH_NACK_LOW,
        PH_NACK_HIGH,
        PH_STOP_LOW,
        PH_STOP_HIGH,
        PH_STOP_RISE
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        stage_t              stage;
        logic [3:0]          bit_count;
        logic [BYTE_W-1:0]   shift_byte;
        logic [BYTE_W-1:0]   ack_wait_count;
        logic                is_read;
        logic [BYTE_W-1:0]   held_device;
        logic [BYTE_W-1:0]   held_register;
        logic [BYTE_W-1:0]   held_data;
        logic [BYTE_W-1:0]   last_read;
    } state_t;

    typedef struct packed {
        logic                scl_level;
        logic                sda_level;
        logic                sda_drive;
        logic                busy_res;
        logic                done_res;
        logic                ack_error;
        logic [BYTE_W-1:0]   read_data;
    } result_t;

    localparam state_t STATE_RESET = '{
        phase:          PH_IDLE,
        stage:          STG_DEVICE,
        bit_count:      4'd0,
        shift_byte:     8'd0,
        ack_wait_count: 8'd0,
        is_read:        1'b0,
        held_device:    8'd0,
        held_register:  8'd0,
        held_data:      8'd0,
        last_read:      8'd0
    };

endpackage

// File: rtl/i2crm_step.sv
// ---------------------------------------------------------------------------
// i2crm_step
// One bus tick of the sequencer: next state and bus levels from the
// current state and one registered input item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2crm_step (
    input  i2crm_pkg::state_t  st,
    input  logic [1:0]         mode,
    input  logic [7:0]         device_address,
    input  logic [7:0]         register_address,
    input  logic [7:0]         write_data,
    input  logic               sda_sample,
    input  logic [7:0]         ack_limit,
    output i2crm_pkg::state_t  st_next,
    output i2crm_pkg::result_t res
);
    import i2crm_pkg::*;

    logic   cmd;
    state_t eff;

    // take a command only when idle; the accepting tick is the first start tick
    assign cmd = (st.phase == PH_IDLE) && ((mode == MODE_WRITE) || (mode == MODE_READ));

    always_comb
    begin
        eff = st;
        if (cmd)
        begin
            eff.phase         = PH_START_HIGH;
            eff.held_device   = device_address;
            eff.held_register = register_address;
            eff.held_data     = write_data;
            eff.is_read       = (mode == MODE_READ);
            eff.bit_count     = 4'd0;
            eff.shift_byte    = device_address;
        end
    end

    // next state
    always_comb
    begin
        st_next = eff;
        unique case (eff.phase)
            PH_IDLE:        st_next.phase = PH_IDLE;
            PH_START_HIGH:  st_next.phase = PH_START_FALL;
            PH_START_FALL:
            begin
                st_next.stage     = (eff.bit_count == BITS_RESTART) ? STG_READ_DEVICE
                                                                    : STG_DEVICE;
                st_next.phase     = PH_BIT_LOW;
                st_next.bit_count = 4'd0;
            end
            PH_RESTART_LOW: st_next.phase = PH_START_HIGH;
            PH_BIT_LOW:     st_next.phase = PH_BIT_HIGH;
            PH_BIT_HIGH:    st_next.phase = PH_BIT_END;
            PH_BIT_END:
            begin
                st_next.shift_byte = {eff.shift_byte[BYTE_W-2:0], 1'b0};
                if (eff.bit_count >= BITS_LAST)
                begin
                    st_next.bit_count = BITS_FULL;
                    st_next.phase     = PH_ACK_LOW;
                end
                else
                begin
                    st_next.bit_count = eff.bit_count + 4'd1;
                    st_next.phase     = PH_BIT_LOW;
                end
            end
            PH_ACK_LOW:
            begin
                st_next.ack_wait_count = 8'd0;
                st_next.phase          = PH_ACK_HIGH;
            end
            PH_ACK_HIGH:
            begin
                if (!sda_sample)
                begin
                    // acknowledged: move on to the next part of the transaction
                    unique case (eff.stage)
                        STG_DEVICE:
                        begin
                            st_next.stage      = STG_REGISTER;
                            st_next.phase      = PH_BIT_LOW;
                            st_next.bit_count  = 4'd0;
                            st_next.shift_byte = eff.held_register;
                        end
                        STG_REGISTER:
                        begin
                            if (eff.is_read)
                            begin
                                st_next.phase      = PH_RESTART_LOW;
                                st_next.bit_count  = BITS_RESTART;
                                st_next.shift_byte = eff.held_device + 8'd1;
                            end
                            else
                            begin
                                st_next.stage      = STG_DATA;
                                st_next.phase      = PH_BIT_LOW;
                                st_next.bit_count  = 4'd0;
                                st_next.shift_byte = eff.held_data;
                            end
                        end
                        STG_DATA:
                        begin
                            st_next.phase     = PH_STOP_LOW;
                            st_next.bit_count = 4'd0;
                        end
                        STG_READ_DEVICE:
                        begin
                            st_next.phase      = PH_READ_LOW;
                            st_next.bit_count  = 4'd0;
                            st_next.shift_byte = 8'd0;
                        end
                    endcase
                end
                else if (eff.ack_wait_count >= ack_limit)
                begin
                    // timed out: abort with stop, error flag in the bit counter
                    st_next.phase     = PH_STOP_LOW;
                    st_next.bit_count = 4'd1;
                end
                else
                begin
                    st_next.ack_wait_count = eff.ack_wait_count + 8'd1;
                end
            end
            PH_READ_LOW:    st_next.phase = PH_READ_HIGH;
            PH_READ_HIGH:
            begin
                st_next.shift_byte = {eff.shift_byte[BYTE_W-2:0], sda_sample};
                if (eff.bit_count >= BITS_LAST)
                begin
                    st_next.last_read = {eff.shift_byte[BYTE_W-2:0], sda_sample};
                    st_next.phase     = PH_NACK_LOW;
                end
                else
                begin
                    st_next.bit_count = eff.bit_count + 4'd1;
                    st_next.phase     = PH_READ_LOW;
                end
            end
            PH_NACK_LOW:    st_next.phase = PH_NACK_HIGH;
            PH_NACK_HIGH:
            begin
                st_next.phase     = PH_STOP_LOW;
                st_next.bit_count = 4'd0;
            end
            PH_STOP_LOW:    st_next.phase = PH_STOP_HIGH;
            PH_STOP_HIGH:   st_next.phase = PH_STOP_RISE;
            PH_STOP_RISE:
            begin
                st_next.bit_count = 4'd0;
                st_next.phase     = PH_IDLE;
            end
        endcase
    end

    // bus levels and status for this tick
    always_comb
    begin
        res.scl_level = 1'b1;
        res.sda_level = 1'b1;
        res.sda_drive = 1'b1;
        res.busy_res  = 1'b1;
        res.done_res  = 1'b0;
        res.ack_error = 1'b0;
        res.read_data = st_next.last_read;
        unique case (eff.phase)
            PH_IDLE:        res.busy_res = 1'b0;
            PH_START_HIGH:  res.scl_level = 1'b1;
            PH_START_FALL:  res.sda_level = 1'b0;
            PH_RESTART_LOW: res.scl_level = 1'b0;
            PH_BIT_LOW, PH_BIT_END:
            begin
                res.scl_level = 1'b0;
                res.sda_level = eff.shift_byte[BYTE_W-1];
            end
            PH_BIT_HIGH:    res.sda_level = eff.shift_byte[BYTE_W-1];
            PH_ACK_LOW, PH_READ_LOW:
            begin
                res.scl_level = 1'b0;
                res.sda_drive = 1'b0;
            end
            PH_ACK_HIGH, PH_READ_HIGH:
                res.sda_drive = 1'b0;
            PH_NACK_LOW:    res.scl_level = 1'b0;
            PH_NACK_HIGH:   res.scl_level = 1'b1;
            PH_STOP_LOW:
            begin
                res.scl_level = 1'b0;
                res.sda_level = 1'b0;
            end
            PH_STOP_HIGH:   res.sda_level = 1'b0;
            PH_STOP_RISE:
            begin
                res.done_res  = 1'b1;
                res.ack_error = eff.bit_count[0];
            end
        endcase
    end

endmodule

// File: rtl/i2c_register_master.sv
// Each input transfer passes through the input register and then the result
// register before it is offered as a result.
// Throughput: one input item per cycle while results are taken; the bus
// sequencer advances one tick per item, and a result held by the receiver
// stalls the input once the input register is also full.
// Reset: asynchronous, active low; sequencer idle, held bytes clear, limit 250.
// ---------------------------------------------------------------------------
// i2c_register_master
// I2C register read/write master, one bus tick per input item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_register_master (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic [7:0] device_address,
    input  logic [7:0] register_address,
    input  logic [7:0] write_data,
    input  logic       sda_sample,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       scl_level,
    output logic       sda_level,
    output logic       sda_drive,
    output logic       busy_res,
    output logic       done_res,
    output logic       ack_error,
    output logic [7:0] read_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);
    import i2crm_pkg::*;

    logic        in_valid_reg;
    logic [1:0]  mode_reg;
    logic [7:0]  device_reg;
    logic [7:0]  register_reg;
    logic [7:0]  data_reg;
    logic        sample_reg;
    logic [7:0]  ack_limit_reg;
    state_t      st_reg;
    state_t      st_next;
    result_t     res_next;
    result_t     res_reg;
    logic        out_valid_reg;
    logic        advance;

    // move an item from the input register to the result register
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ack_limit_reg <= ACK_LIMIT_RESET;
        else if (cfg_valid)
            ack_limit_reg <= cfg_data;
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    // hold the payload of each transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg     <= mode;
            device_reg   <= device_address;
            register_reg <= register_address;
            data_reg     <= write_data;
            sample_reg   <= sda_sample;
        end
    end

    i2crm_step u_step (
        .st               (st_reg),
        .mode             (mode_reg),
        .device_address   (device_reg),
        .register_address (register_reg),
        .write_data       (data_reg),
        .sda_sample       (sample_reg),
        .ack_limit        (ack_limit_reg),
        .st_next          (st_next),
        .res              (res_next)
    );

    // advance the sequencer once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= STATE_RESET;
        else if (advance)
            st_reg <= st_next;
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign scl_level = res_reg.scl_level;
    assign sda_level = res_reg.sda_level;
    assign sda_drive = res_reg.sda_drive;
    assign busy_res  = res_reg.busy_res;
    assign done_res  = res_reg.done_res;
    assign ack_error = res_reg.ack_error;
    assign read_data = res_reg.read_data;

endmodule

// File: rtl/i2crm_checker.sv
// ---------------------------------------------------------------------------
// i2crm_checker
// Port-level checks on the result channel of the I2C register master.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2crm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       scl_level,
    input logic       sda_level,
    input logic       sda_drive,
    input logic       busy_res,
    input logic       done_res,
    input logic       ack_error,
    input logic [7:0] read_data
);

    // a stalled result holds its bus levels and data
    `CHK_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> $stable(scl_level) && $stable(sda_level) && $stable(sda_drive) && $stable(read_data))

    // a finished transaction is still flagged busy
    `CHK_NEVER(a_done_busy, clk, rst_n, out_valid && done_res && !busy_res)

    // an error only comes with done
    `CHK_NEVER(a_err_done, clk, rst_n, out_valid && ack_error && !done_res)

    // released SDA reads as high
    `CHK_NEVER(a_release_high, clk, rst_n, out_valid && !sda_drive && !sda_level)

    // idle bus: both lines driven high
    `CHK_ASSERT(a_idle_bus, clk, rst_n, out_valid && !busy_res |-> scl_level && sda_level && sda_drive)

endmodule

bind i2c_register_master i2crm_checker u_checker (.*);

// File: tb/i2c_register_master_tb.sv
// ---------------------------------------------------------------------------
// i2c_register_master_tb
// Self-checking bench for the I2C register master. Each input transfer is one
// bus tick; a bus model predicts the levels and flags of every tick and the
// acknowledge and read-back behaviour follows scripted or random responder
// plans. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_register_master_tb;

    import i2crm_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 4;
    localparam int ITEM_TARGET   = 1950;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 200;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int REPORT_LIMIT  = 10;
    localparam int NEVER_ACK     = 1000;

    // mode codes that start nothing
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] mode = MODE_TICK;
    logic [7:0] device_address = '0;
    logic [7:0] register_address = '0;
    logic [7:0] write_data = '0;
    logic       sda_sample = 1'b1;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic       ack_error;
    logic [7:0] read_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = '0;

    // bus model state
    phase_t     bus_phase = PH_IDLE;
    stage_t     bus_stage = STG_DEVICE;
    logic [3:0] bit_cnt = '0;
    logic [7:0] shifter = '0;
    logic [7:0] ack_cnt = '0;
    logic       read_op = 1'b0;
    logic [7:0] held_dev = '0;
    logic [7:0] held_reg = '0;
    logic [7:0] held_dat = '0;
    logic [7:0] last_rx = '0;
    logic [7:0] ack_limit = ACK_LIMIT_RESET;

    // responder plans
    int         ack_script[$];
    int         ack_plan = 0;
    int         nack_pct = 0;
    int         slow_pct = 0;
    logic [7:0] rx_pattern = '0;

    result_t    pending_ticks[$];
    int         items_sent = 0;
    int         mismatches = 0;
    int         cycles = 0;
    bit         tx_calm = 1'b0;
    bit         rx_calm = 1'b0;
    int         hold_requests = 0;
    int         hold_served = 0;
    int         rx_left = 0;

    i2c_register_master dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .device_address   (device_address),
        .register_address (register_address),
        .write_data       (write_data),
        .sda_sample       (sda_sample),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .scl_level        (scl_level),
        .sda_level        (sda_level),
        .sda_drive        (sda_drive),
        .busy_res         (busy_res),
        .done_res         (done_res),
        .ack_error        (ack_error),
        .read_data        (read_data),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // abort a run that hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d ticks outstanding", cycles,
                     pending_ticks.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic void enter_byte(stage_t stg, logic [7:0] value);
        bus_phase = PH_BIT_LOW;
        bus_stage = stg;
        bit_cnt = '0;
        shifter = value;
    endfunction

    function automatic void enter_stop(logic err);
        bus_phase = PH_STOP_LOW;
        bit_cnt = {3'b000, err};
    endfunction

    // advance the bus model by one tick and return the levels it drives
    function automatic result_t bus_tick(logic [1:0] md, logic [7:0] dev,
                                         logic [7:0] raddr, logic [7:0] dat,
                                         logic smp);
        result_t r;
        r.scl_level = 1'b1;
        r.sda_level = 1'b1;
        r.sda_drive = 1'b1;
        r.busy_res  = 1'b1;
        r.done_res  = 1'b0;
        r.ack_error = 1'b0;

        // latch a command only while idle; the same tick starts the bus
        if (bus_phase == PH_IDLE && (md == MODE_WRITE || md == MODE_READ))
        begin
            held_dev = dev;
            held_reg = raddr;
            held_dat = dat;
            read_op = (md == MODE_READ);
            bus_phase = PH_START_HIGH;
            bit_cnt = '0;
            shifter = dev;
        end

        case (bus_phase)
            PH_START_HIGH:
                bus_phase = PH_START_FALL;
            PH_START_FALL:
            begin
                r.sda_level = 1'b0;
                enter_byte(bit_cnt == BITS_RESTART ? STG_READ_DEVICE : STG_DEVICE, shifter);
            end
            PH_RESTART_LOW:
            begin
                r.scl_level = 1'b0;
                bus_phase = PH_START_HIGH;
            end
            PH_BIT_LOW:
            begin
                r.scl_level = 1'b0;
                r.sda_level = shifter[7];
                bus_phase = PH_BIT_HIGH;
            end
            PH_BIT_HIGH:
            begin
                r.sda_level = shifter[7];
                bus_phase = PH_BIT_END;
            end
            PH_BIT_END:
            begin
                r.scl_level = 1'b0;
                r.sda_level = shifter[7];
                shifter = shifter << 1;
                if (bit_cnt >= BITS_LAST)
                begin
                    bit_cnt = BITS_FULL;
                    bus_phase = PH_ACK_LOW;
                end
                else
                begin
                    bit_cnt = bit_cnt + 4'd1;
                    bus_phase = PH_BIT_LOW;
                end
            end
            PH_ACK_LOW:
            begin
                r.scl_level = 1'b0;
                r.sda_drive = 1'b0;
                ack_cnt = '0;
                bus_phase = PH_ACK_HIGH;
            end
            PH_ACK_HIGH:
            begin
                r.sda_drive = 1'b0;
                if (!smp)
                begin
                    // acknowledged: move on to whatever follows this byte
                    case (bus_stage)
                        STG_DEVICE:
                            enter_byte(STG_REGISTER, held_reg);
                        STG_REGISTER:
                            if (read_op)
                            begin
                                bus_phase = PH_RESTART_LOW;
                                bit_cnt = BITS_RESTART;
                                shifter = held_dev + 8'd1;
                            end
                            else
                                enter_byte(STG_DATA, held_dat);
                        STG_DATA:
                            enter_stop(1'b0);
                        default:
                        begin
                            bus_phase = PH_READ_LOW;
                            bit_cnt = '0;
                            shifter = '0;
                        end
                    endcase
                end
                else if (ack_cnt >= ack_limit)
                    enter_stop(1'b1);
                else
                    ack_cnt = ack_cnt + 8'd1;
            end
            PH_READ_LOW:
            begin
                r.scl_level = 1'b0;
                r.sda_drive = 1'b0;
                bus_phase = PH_READ_HIGH;
            end
            PH_READ_HIGH:
            begin
                r.sda_drive = 1'b0;
                shifter = {shifter[6:0], smp};
                if (bit_cnt >= BITS_LAST)
                begin
                    last_rx = shifter;
                    bus_phase = PH_NACK_LOW;
                end
                else
                begin
                    bit_cnt = bit_cnt + 4'd1;
                    bus_phase = PH_READ_LOW;
                end
            end
            PH_NACK_LOW:
            begin
                r.scl_level = 1'b0;
                bus_phase = PH_NACK_HIGH;
            end
            PH_NACK_HIGH:
                enter_stop(1'b0);
            PH_STOP_LOW:
            begin
                r.scl_level = 1'b0;
                r.sda_level = 1'b0;
                bus_phase = PH_STOP_HIGH;
            end
            PH_STOP_HIGH:
            begin
                r.sda_level = 1'b0;
                bus_phase = PH_STOP_RISE;
            end
            PH_STOP_RISE:
            begin
                r.done_res = 1'b1;
                r.ack_error = bit_cnt[0];
                bit_cnt = '0;
                bus_phase = PH_IDLE;
            end
            default:
                r.busy_res = 1'b0;
        endcase

        if (!r.sda_drive)
            r.sda_level = 1'b1;
        r.read_data = last_rx;
        return r;
    endfunction

    // SDA level the responder presents on the next tick
    function automatic logic next_sample();
        int r;
        case (bus_phase)
            PH_ACK_LOW:
            begin
                // pick how many high samples this acknowledge window sees
                if (ack_script.size() != 0)
                    ack_plan = ack_script.pop_front();
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < nack_pct)
                        ack_plan = NEVER_ACK;
                    else if (r < nack_pct + slow_pct)
                        ack_plan = $urandom_range(3, 40);
                    else
                        ack_plan = $urandom_range(0, 2);
                end
                return 1'($urandom_range(0, 1));
            end
            PH_ACK_HIGH:
                return int'(ack_cnt) < ack_plan;
            PH_READ_HIGH:
                return rx_pattern[3'd7 - bit_cnt[2:0]];
            default:
                return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // mostly plain ticks, sometimes a command that must be ignored
    function automatic logic [1:0] busy_mode();
        if ($urandom_range(0, 1) == 0)
            return MODE_TICK;
        return 2'($urandom_range(0, 3));
    endfunction

    // offer one tick and record its prediction once the transfer happens
    task automatic send_tick(input logic [1:0] md, input logic [7:0] dev,
                             input logic [7:0] raddr, input logic [7:0] dat,
                             input logic smp);
        if (!tx_calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat (pick_gap()) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= md;
        device_address <= dev;
        register_address <= raddr;
        write_data <= dat;
        sda_sample <= smp;
        do
            @(posedge clk);
        while (!in_ready);
        pending_ticks.push_back(bus_tick(md, dev, raddr, dat, smp));
        items_sent++;
    endtask

    task automatic idle_ticks(input int n);
        repeat (n)
            send_tick($urandom_range(0, 1) ? MODE_TICK : MODE_SPARE, 8'($urandom),
                      8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // keep ticking until the bus model is back at idle
    task automatic run_to_idle();
        while (bus_phase != PH_IDLE)
            send_tick(busy_mode(), 8'($urandom), 8'($urandom), 8'($urandom), next_sample());
        ack_script.delete();
    endtask

    task automatic run_transfer(input logic [1:0] md, input logic [7:0] dev,
                                input logic [7:0] raddr, input logic [7:0] dat,
                                input logic [7:0] rd_byte);
        rx_pattern = rd_byte;
        send_tick(md, dev, raddr, dat, 1'($urandom_range(0, 1)));
        run_to_idle();
    endtask

    // drop valid and wait for every predicted tick to come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_ticks.size() != 0);
    endtask

    task automatic set_ack_limit(input logic [7:0] lim);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= lim;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        ack_limit = lim;
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want,
                         got);
        end
    endtask

    // receiver: random stalls, plus a long hold when a test requests one
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            rx_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (rx_left > 0)
        begin
            rx_left <= rx_left - 1;
            out_ready <= 1'b0;
        end
        else if (rx_calm || $urandom_range(0, 4) != 0)
            out_ready <= 1'b1;
        else
        begin
            out_ready <= 1'b0;
            rx_left <= pick_gap() - 1;
        end
    end

    // compare every result transfer with the oldest prediction
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_ticks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with no tick outstanding", $realtime);
            end
            else
            begin
                want = pending_ticks.pop_front();
                compare_field("scl_level", 8'(want.scl_level), 8'(scl_level));
                compare_field("sda_level", 8'(want.sda_level), 8'(sda_level));
                compare_field("sda_drive", 8'(want.sda_drive), 8'(sda_drive));
                compare_field("busy_res", 8'(want.busy_res), 8'(busy_res));
                compare_field("done_res", 8'(want.done_res), 8'(done_res));
                compare_field("ack_error", 8'(want.ack_error), 8'(ack_error));
                compare_field("read_data", want.read_data, read_data);
            end
        end
    end

    // plain and spare-mode ticks while idle, fields at their extremes
    task automatic test_idle_ticks();
        send_tick(MODE_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        send_tick(MODE_SPARE, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_tick(MODE_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_tick(MODE_SPARE, 8'h00, 8'h00, 8'h00, 1'b0);
        idle_ticks(3);
    endtask

    task automatic test_register_write();
        ack_script = '{0, 0, 0};
        run_transfer(MODE_WRITE, 8'hFF, 8'h00, 8'hA5, 8'h00);
        ack_script = '{2, 1, 2};
        run_transfer(MODE_WRITE, 8'h00, 8'hFF, 8'h5A, 8'h00);
        idle_ticks(2);
    endtask

    // read address wraps from 0xFF to 0x00
    task automatic test_register_read();
        run_transfer(MODE_READ, 8'hFF, 8'h80, 8'h00, 8'h96);
        run_transfer(MODE_READ, 8'h00, 8'h7F, 8'hFF, 8'hFF);
        run_transfer(MODE_READ, 8'hA0, 8'h01, 8'h5A, 8'h00);
    endtask

    task automatic test_ack_timeout();
        set_ack_limit(8'd0);
        // zero limit: first high sample aborts, prompt acks still pass
        ack_script = '{NEVER_ACK};
        run_transfer(MODE_WRITE, 8'hD0, 8'h10, 8'h33, 8'h00);
        ack_script = '{0, 0, 0};
        run_transfer(MODE_WRITE, 8'hD0, 8'h11, 8'hCC, 8'h00);
        // abort on the read address byte: last read byte must stay
        ack_script = '{0, 0, NEVER_ACK};
        run_transfer(MODE_READ, 8'hD0, 8'h12, 8'h00, 8'h3C);
        set_ack_limit(8'd4);
        ack_script = '{4, NEVER_ACK};
        run_transfer(MODE_WRITE, 8'h42, 8'h24, 8'h81, 8'h00);
        set_ack_limit(8'd255);
        ack_script = '{255, 0, NEVER_ACK};
        run_transfer(MODE_WRITE, 8'h7E, 8'hE7, 8'h18, 8'h00);
    endtask

    // lower the limit while a slave is holding off the acknowledge
    task automatic test_limit_change_mid();
        set_ack_limit(ACK_LIMIT_RESET);
        ack_script = '{NEVER_ACK};
        send_tick(MODE_WRITE, 8'h3C, 8'hC3, 8'h99, 1'b1);
        while (!(bus_phase == PH_ACK_HIGH && ack_cnt >= 8'd6))
            send_tick(busy_mode(), 8'($urandom), 8'($urandom), 8'($urandom), next_sample());
        set_ack_limit(8'd2);
        run_to_idle();
    endtask

    // hold the result side off while ticks keep coming
    task automatic test_output_stall();
        tx_calm = 1'b1;
        hold_requests++;
        run_transfer(MODE_READ, 8'h55, 8'hAA, 8'h0F, 8'hF0);
        tx_calm = 1'b0;
    endtask

    // random transactions until the run has sent its share of items
    task automatic test_random_traffic();
        int target;
        int pick;
        target = ITEM_TARGET;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    set_ack_limit(8'd0);
                else if (pick == 1)
                    set_ack_limit(8'd255);
                else
                    set_ack_limit(8'($urandom_range(1, 12)));
            end
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            nack_pct = $urandom_range(0, 12);
            slow_pct = $urandom_range(0, 30);
            idle_ticks($urandom_range(0, 3));
            run_transfer($urandom_range(0, 1) ? MODE_READ : MODE_WRITE, 8'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom));
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_idle_ticks();
        test_register_write();
        test_register_read();
        test_ack_timeout();
        test_limit_change_mid();
        test_output_stall();
        test_random_traffic();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_ticks.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: i2c_register_master.f
+incdir+rtl
rtl/i2crm_pkg.sv
rtl/i2crm_step.sv
rtl/i2c_register_master.sv
rtl/i2crm_checker.sv
tb/i2c_register_master_tb.sv
